[rtl/mcmm_pkg.sv]
// Package for the machine configuration memory mapper.
// Holds port addresses, page numbers, codes and shared types.
// No dependencies.
package mcmm_pkg;

    localparam logic [15:0] PORT_MODE   = 16'h24DB;
    localparam logic [15:0] PORT_OPTION = 16'h24DD;
    localparam logic [15:0] PORT_TURBO  = 16'h24DF;
    localparam logic [15:0] PORT_RESET  = 16'h24D9;
    localparam logic [15:0] PORT_ID     = 16'h24D5;

    localparam int PAGE_W    = 6;
    localparam int CFG_IDX_W = 1;

    typedef logic [PAGE_W-1:0] t_page;

    localparam t_page RAM_BASE    = 6'd16;
    localparam t_page ROM_BASE    = 6'd28;
    localparam t_page LOADER_PAGE = 6'd32;

    localparam logic [7:0] HW_ID_RESET  = 8'd8;
    localparam logic [7:0] FW_VER_RESET = 8'd0;
    localparam logic [7:0] READ_IDLE    = 8'hFF;
    localparam logic [1:0] ID_CNT_MAX   = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HW_ID  = 1'b0,
        CFG_FW_VER = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_READ  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        MODE_CONFIG = 2'd0,
        MODE_48K    = 2'd1,
        MODE_128K   = 2'd2,
        MODE_PLUS3  = 2'd3
    } t_mode;

    // RAM bank per slot for the +3 all-RAM layouts
    localparam logic [2:0] SPECIAL_LAYOUT [4][4] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3},
        '{3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd4, 3'd5, 3'd6, 3'd3},
        '{3'd4, 3'd7, 3'd6, 3'd3}
    };

    typedef struct packed {
        t_page [3:0] slot;
        logic        wr;
    } t_map;

    typedef struct packed {
        logic [7:0] read_data;
        t_map       map;
        logic       cpu_restart;
        logic       divmmc_enable;
        logic       ulaplus_enable;
        logic       turbo_enable;
        logic       timing_128k;
    } t_result;

endpackage

[rtl/mcmm_ifs.sv]
// Channel interfaces of the machine configuration memory mapper:
// access requests in, mapping results out, register writes.
// Depends on mcmm_pkg.
interface mcmm_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] port;
    logic [7:0]  data;
    logic [7:0]  bank_7ffd;
    logic [7:0]  bank_1ffd;

    modport source (output valid, kind, port, data, bank_7ffd, bank_1ffd, input ready);
    modport sink   (input valid, kind, port, data, bank_7ffd, bank_1ffd, output ready);
endinterface

interface mcmm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [5:0] slot0_page;
    logic [5:0] slot1_page;
    logic [5:0] slot2_page;
    logic [5:0] slot3_page;
    logic       low_writable;
    logic       cpu_restart;
    logic       divmmc_enable;
    logic       ulaplus_enable;
    logic       turbo_enable;
    logic       timing_128k;

    modport source (output valid, read_data, slot0_page, slot1_page, slot2_page,
                    slot3_page, low_writable, cpu_restart, divmmc_enable,
                    ulaplus_enable, turbo_enable, timing_128k, input ready);
    modport sink   (input valid, read_data, slot0_page, slot1_page, slot2_page,
                    slot3_page, low_writable, cpu_restart, divmmc_enable,
                    ulaplus_enable, turbo_enable, timing_128k, output ready);
endinterface

interface mcmm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mcmm_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                     wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

[rtl/mcmm_map.sv]
// Slot page mapper: physical 16K page per CPU slot and slot 0 write enable
// from the mode byte, boot ROM flag and the two paging bytes.
// Depends on mcmm_pkg.
module mcmm_map (
    input  logic [7:0]     i_mode_byte,
    input  logic           i_boot_rom,
    input  logic [7:0]     i_bank_7ffd,
    input  logic [7:0]     i_bank_1ffd,
    output mcmm_pkg::t_map o_map
);
    import mcmm_pkg::*;

    logic [2:0] ram;
    logic       rom_lo;
    logic [1:0] lay;

    assign ram    = i_bank_7ffd[2:0];
    assign rom_lo = i_bank_7ffd[4];
    assign lay    = i_bank_1ffd[2:1];

    always_comb begin
        o_map.slot[1] = RAM_BASE + 6'd5;
        o_map.slot[2] = RAM_BASE + 6'd2;
        o_map.slot[0] = ROM_BASE;
        o_map.slot[3] = RAM_BASE;
        o_map.wr      = 1'b0;
        unique case (t_mode'(i_mode_byte[7:6]))
            MODE_48K: begin
                o_map.slot[0] = ROM_BASE;
                o_map.slot[3] = RAM_BASE;
            end
            MODE_128K: begin
                o_map.slot[0] = ROM_BASE + {5'd0, rom_lo};
                o_map.slot[3] = RAM_BASE + {3'd0, ram};
            end
            MODE_PLUS3: begin
                if (i_bank_1ffd[0]) begin
                    for (int k = 0; k < 4; k++) begin
                        o_map.slot[k] = RAM_BASE + {3'd0, SPECIAL_LAYOUT[lay][k]};
                    end
                    o_map.wr = 1'b1;
                end else begin
                    o_map.slot[0] = ROM_BASE + {4'd0, i_bank_1ffd[2], rom_lo};
                    o_map.slot[3] = RAM_BASE + {3'd0, ram};
                end
            end
            MODE_CONFIG: begin
                if (i_boot_rom) begin
                    o_map.slot[0] = LOADER_PAGE;
                end else begin
                    o_map.slot[0] = {1'b0, i_mode_byte[4:0]};
                    o_map.wr      = 1'b1;
                end
                o_map.slot[3] = RAM_BASE + 6'd7;
            end
            default: begin
                o_map.wr = 1'b0;
            end
        endcase
    end

endmodule

[rtl/machine_config_memory_mapper.sv]
// Top level of the machine configuration memory mapper.
// Depends on mcmm_pkg, mcmm_ifs (channel interfaces) and mcmm_map.
//
// Use: each request on i_in is one CPU I/O access (port write or read) with
// the current 128K and +3 paging bytes. Control port writes update the mode,
// option and turbo bytes, clear the boot ROM flag or raise a soft or hard
// reset; id port reads return hardware id, firmware version, then 255.
// Every request gives exactly one result on o_out with the read byte, the
// page of each 16K slot, slot 0 write enable and the mode flags, all taken
// after the request's own state update.
// i_cfg writes the hardware id (index 0) and firmware version (index 1);
// it is always ready; it must be written only while no request is in flight, which the block itself does not enforce.
// A request passes through the input register and then the result register;
// the state update and the mapper sit between those two registers. One request
// per cycle is taken while the receiver does not stall.
// When the receiver stalls the result register holds, the input register
// fills behind it, and i_in.ready drops only when both are full.
// Reset: mode, option and turbo bytes cleared, boot ROM mapped, id read
// count cleared, hardware id 8, firmware version 0, both stages empty.
module machine_config_memory_mapper (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mcmm_in_if.sink       i_in,
    mcmm_out_if.source    o_out,
    mcmm_cfg_if.sink      i_cfg
);
    import mcmm_pkg::*;

    logic        r_in_valid;
    logic        r_kind;
    logic [15:0] r_port;
    logic [7:0]  r_data;
    logic [7:0]  r_bank_7ffd;
    logic [7:0]  r_bank_1ffd;

    logic        r_out_valid;
    t_result     r_out;

    logic [7:0]  r_hw_id;
    logic [7:0]  r_fw_ver;
    logic [7:0]  r_mode;
    logic [7:0]  r_option;
    logic [7:0]  r_turbo;
    logic        r_boot_rom;
    logic [1:0]  r_id_cnt;

    logic [7:0]  n_mode;
    logic [7:0]  n_option;
    logic [7:0]  n_turbo;
    logic        n_boot_rom;
    logic [1:0]  n_id_cnt;
    t_result     n_out;
    t_map        map;

    logic        adv;
    logic        in_take;

    assign adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_take = i_in.valid && i_in.ready;

    assign i_in.ready  = !r_in_valid || adv;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_mode               = r_mode;
        n_option             = r_option;
        n_turbo              = r_turbo;
        n_boot_rom           = r_boot_rom;
        n_id_cnt             = r_id_cnt;
        n_out.read_data      = READ_IDLE;
        n_out.cpu_restart    = 1'b0;
        if (t_kind'(r_kind) == KIND_WRITE) begin
            priority if (r_port == PORT_MODE) begin
                n_mode     = r_data;
                n_boot_rom = 1'b0;
            end else if (r_port == PORT_OPTION) begin
                n_option = r_data;
            end else if (r_port == PORT_TURBO) begin
                n_turbo = r_data;
            end else if (r_port == PORT_RESET) begin
                n_out.cpu_restart = r_data[0] | r_data[1];
                if (r_data[1]) begin
                    n_boot_rom = 1'b1;
                    n_mode     = 8'd0;
                end
            end else begin
                n_out.cpu_restart = 1'b0;
            end
        end else if (r_port == PORT_ID) begin
            priority if (r_id_cnt == 2'd0) begin
                n_out.read_data = r_hw_id;
            end else if (r_id_cnt == 2'd1) begin
                n_out.read_data = r_fw_ver;
            end else begin
                n_out.read_data = READ_IDLE;
            end
            if (r_id_cnt < ID_CNT_MAX) begin
                n_id_cnt = r_id_cnt + 2'd1;
            end
        end
        n_out.map            = map;
        n_out.divmmc_enable  = n_option[2];
        n_out.ulaplus_enable = n_option[3];
        n_out.turbo_enable   = n_turbo[2];
        n_out.timing_128k    = n_mode[7];
    end

    mcmm_map u_map (
        .i_mode_byte (n_mode),
        .i_boot_rom  (n_boot_rom),
        .i_bank_7ffd (r_bank_7ffd),
        .i_bank_1ffd (r_bank_1ffd),
        .o_map       (map)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hw_id     <= HW_ID_RESET;
            r_fw_ver    <= FW_VER_RESET;
            r_mode      <= 8'd0;
            r_option    <= 8'd0;
            r_turbo     <= 8'd0;
            r_boot_rom  <= 1'b1;
            r_id_cnt    <= 2'd0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_option    <= n_option;
                r_turbo     <= n_turbo;
                r_boot_rom  <= n_boot_rom;
                r_id_cnt    <= n_id_cnt;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_HW_ID:  r_hw_id  <= i_cfg.wdata;
                    CFG_FW_VER: r_fw_ver <= i_cfg.wdata;
                    default:    r_hw_id  <= r_hw_id;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind      <= i_in.kind;
            r_port      <= i_in.port;
            r_data      <= i_in.data;
            r_bank_7ffd <= i_in.bank_7ffd;
            r_bank_1ffd <= i_in.bank_1ffd;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.read_data      = r_out.read_data;
    assign o_out.slot0_page     = r_out.map.slot[0];
    assign o_out.slot1_page     = r_out.map.slot[1];
    assign o_out.slot2_page     = r_out.map.slot[2];
    assign o_out.slot3_page     = r_out.map.slot[3];
    assign o_out.low_writable   = r_out.map.wr;
    assign o_out.cpu_restart    = r_out.cpu_restart;
    assign o_out.divmmc_enable  = r_out.divmmc_enable;
    assign o_out.ulaplus_enable = r_out.ulaplus_enable;
    assign o_out.turbo_enable   = r_out.turbo_enable;
    assign o_out.timing_128k    = r_out.timing_128k;

    a_id_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id_cnt != 2'd3)
        else $error("id read count past saturation");

    a_mode_write_clears_boot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && t_kind'(r_kind) == KIND_WRITE && r_port == PORT_MODE
        |=> !r_boot_rom && r_mode == $past(r_data))
        else $error("mode write did not take effect");

    a_loader_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.map.slot[0] == LOADER_PAGE |-> !r_out.map.wr)
        else $error("loader page mapped writable");

    a_stalled_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_port) && $stable(r_data))
        else $error("pending request lost while stalled");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("result register not loaded");

endmodule

[sim/tb_machine_config_memory_mapper.sv]
// Testbench for machine_config_memory_mapper: a directed table, partly with its own
// expected results, then random port accesses; the rest checked against a predictor of the mode, paging and id logic.
// Depends on mcmm_pkg, mcmm_ifs and the RTL top level.
module tb_machine_config_memory_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    import mcmm_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASES       = 4;
    localparam int DRAIN_CYCLES = 10;
    localparam longint TIMEOUT_NS = 2_000_000;

    localparam logic [2:0] ALLRAM_BANKS [4][4] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3},
        '{3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd4, 3'd5, 3'd6, 3'd3},
        '{3'd4, 3'd7, 3'd6, 3'd3}
    };
    localparam logic [15:0] CTRL_PORTS [5] = '{
        PORT_MODE, PORT_OPTION, PORT_TURBO, PORT_RESET, PORT_ID
    };

    typedef struct packed {
        t_kind       kind;
        logic [15:0] port;
        logic [7:0]  data;
        logic [7:0]  b7ffd;
        logic [7:0]  b1ffd;
    } t_access;

    typedef enum {ROW_ACCESS, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind  what;
        t_access    acc;
        t_cfg_idx   idx;
        logic [7:0] value;
        bit         typed;
        t_result    want;
    } t_row;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mcmm_in_if  in_if ();
    mcmm_out_if out_if ();
    mcmm_cfg_if cfg_if ();

    machine_config_memory_mapper u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state
    logic [7:0] cur_mode_byte  = '0;
    logic [7:0] cur_opt_byte   = '0;
    logic [7:0] cur_turbo_byte = '0;
    logic       loader_mapped  = 1'b1;
    logic [1:0] id_reads       = '0;
    logic [7:0] id_value       = HW_ID_RESET;
    logic [7:0] fw_value       = FW_VER_RESET;

    t_result pending_results[$];
    int      mismatches = 0;
    int      burst_left = 0;
    int      rx_cycle   = 0;
    t_stall  rx_mode    = STALL_NONE;

    function automatic t_result predict_access(t_access a);
        t_result r;
        t_mode   mode;
        r = '0;
        r.read_data = READ_IDLE;
        if (a.kind == KIND_WRITE) begin
            case (a.port)
                PORT_MODE: begin
                    cur_mode_byte = a.data;
                    loader_mapped = 1'b0;
                end
                PORT_OPTION: cur_opt_byte = a.data;
                PORT_TURBO:  cur_turbo_byte = a.data;
                PORT_RESET: begin
                    r.cpu_restart = a.data[0] | a.data[1];
                    if (a.data[1]) begin
                        loader_mapped = 1'b1;
                        cur_mode_byte = '0;
                    end
                end
                default: ;
            endcase
        end else if (a.port == PORT_ID) begin
            case (id_reads)
                2'd0:    r.read_data = id_value;
                2'd1:    r.read_data = fw_value;
                default: r.read_data = READ_IDLE;
            endcase
            if (id_reads < ID_CNT_MAX) id_reads++;
        end

        mode = t_mode'(cur_mode_byte[7:6]);
        r.map.slot[1] = RAM_BASE + 6'd5;
        r.map.slot[2] = RAM_BASE + 6'd2;
        r.map.slot[3] = RAM_BASE + t_page'(a.b7ffd[2:0]);
        case (mode)
            MODE_48K: begin
                r.map.slot[0] = ROM_BASE;
                r.map.slot[3] = RAM_BASE;
            end
            MODE_128K: r.map.slot[0] = ROM_BASE + t_page'(a.b7ffd[4]);
            MODE_PLUS3: begin
                if (a.b1ffd[0]) begin
                    for (int k = 0; k < 4; k++)
                        r.map.slot[k] = RAM_BASE + t_page'(ALLRAM_BANKS[a.b1ffd[2:1]][k]);
                    r.map.wr = 1'b1;
                end else begin
                    r.map.slot[0] = ROM_BASE + t_page'({a.b1ffd[2], a.b7ffd[4]});
                end
            end
            default: begin
                r.map.slot[3] = RAM_BASE + 6'd7;
                if (loader_mapped) begin
                    r.map.slot[0] = LOADER_PAGE;
                end else begin
                    r.map.slot[0] = t_page'(cur_mode_byte[4:0]);
                    r.map.wr = 1'b1;
                end
            end
        endcase
        r.divmmc_enable  = cur_opt_byte[2];
        r.ulaplus_enable = cur_opt_byte[3];
        r.turbo_enable   = cur_turbo_byte[2];
        r.timing_128k    = cur_mode_byte[7];
        return r;
    endfunction

    function automatic t_result mk_result(logic [7:0] rd, int s0, int s1, int s2,
                                          int s3, int wr, int rst, int dv,
                                          int ul, int tu, int tm);
        t_result r;
        r.read_data      = rd;
        r.map.slot[0]    = t_page'(s0);
        r.map.slot[1]    = t_page'(s1);
        r.map.slot[2]    = t_page'(s2);
        r.map.slot[3]    = t_page'(s3);
        r.map.wr         = 1'(wr);
        r.cpu_restart    = 1'(rst);
        r.divmmc_enable  = 1'(dv);
        r.ulaplus_enable = 1'(ul);
        r.turbo_enable   = 1'(tu);
        r.timing_128k    = 1'(tm);
        return r;
    endfunction

    function automatic t_row access_row(t_kind k, logic [15:0] p, logic [7:0] d,
                                        logic [7:0] b7, logic [7:0] b1);
        t_row r;
        r.what  = ROW_ACCESS;
        r.acc   = '{kind: k, port: p, data: d, b7ffd: b7, b1ffd: b1};
        r.idx   = CFG_HW_ID;
        r.value = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_row checked(t_row r, t_result w);
        t_row c;
        c = r;
        c.typed = 1'b1;
        c.want  = w;
        return c;
    endfunction

    function automatic t_row reg_row(t_cfg_idx i, logic [7:0] v);
        t_row r;
        r = access_row(KIND_WRITE, '0, '0, '0, '0);
        r.what  = ROW_REG;
        r.idx   = i;
        r.value = v;
        return r;
    endfunction

    function automatic t_access rand_access();
        t_access a;
        int      sel;
        sel     = $urandom_range(0, 99);
        a.kind  = KIND_WRITE;
        a.data  = 8'($urandom_range(0, 255));
        a.b7ffd = 8'($urandom_range(0, 255));
        a.b1ffd = 8'($urandom_range(0, 255));
        if (sel < 30) begin
            a.port = PORT_MODE;
        end else if (sel < 40) begin
            a.port = PORT_OPTION;
        end else if (sel < 48) begin
            a.port = PORT_TURBO;
        end else if (sel < 55) begin
            a.port = PORT_RESET;
        end else if (sel < 70) begin
            a.kind = KIND_READ;
            a.port = PORT_ID;
        end else if (sel < 85) begin
            a.kind = t_kind'($urandom_range(0, 1));
            a.port = 16'($urandom_range(0, 65535));
        end else begin
            // near miss on a control port address
            a.kind = t_kind'($urandom_range(0, 1));
            a.port = CTRL_PORTS[$urandom_range(0, 4)] ^ (16'h1 << $urandom_range(0, 15));
        end
        return a;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // called just after a falling edge; returns just after a falling edge
    task automatic send_access(t_access a, bit typed, t_result want);
        t_result predicted;
        in_if.valid     <= 1'b1;
        in_if.kind      <= a.kind;
        in_if.port      <= a.port;
        in_if.data      <= a.data;
        in_if.bank_7ffd <= a.b7ffd;
        in_if.bank_1ffd <= a.b1ffd;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predicted = predict_access(a);
        pending_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic write_register(t_cfg_idx idx, logic [7:0] v);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= v;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            CFG_HW_ID:  id_value = v;
            CFG_FW_VER: fw_value = v;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // result receiver: drives ready by a stall pattern that is redrawn at random as rx_cycle counts on
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 256 == 0) rx_mode = t_stall'($urandom_range(0, 3));
        case (rx_mode)
            STALL_NONE:  out_if.ready <= 1'b1;
            STALL_LIGHT: out_if.ready <= ($urandom_range(0, 3) != 0);
            STALL_HEAVY: out_if.ready <= ($urandom_range(0, 3) == 0);
            default:     out_if.ready <= (rx_cycle % 5 >= 2);
        endcase
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = pending_results.pop_front();
                check_field("read_data", out_if.read_data, want.read_data);
                check_field("slot0_page", 8'(out_if.slot0_page), 8'(want.map.slot[0]));
                check_field("slot1_page", 8'(out_if.slot1_page), 8'(want.map.slot[1]));
                check_field("slot2_page", 8'(out_if.slot2_page), 8'(want.map.slot[2]));
                check_field("slot3_page", 8'(out_if.slot3_page), 8'(want.map.slot[3]));
                check_field("low_writable", 8'(out_if.low_writable), 8'(want.map.wr));
                check_field("cpu_restart", 8'(out_if.cpu_restart), 8'(want.cpu_restart));
                check_field("divmmc_enable", 8'(out_if.divmmc_enable),
                            8'(want.divmmc_enable));
                check_field("ulaplus_enable", 8'(out_if.ulaplus_enable),
                            8'(want.ulaplus_enable));
                check_field("turbo_enable", 8'(out_if.turbo_enable), 8'(want.turbo_enable));
                check_field("timing_128k", 8'(out_if.timing_128k), 8'(want.timing_128k));
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_row       rows[$];
        logic [7:0] hw_val;
        logic [7:0] fw_val;

        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.kind      = KIND_WRITE;
        in_if.port      = '0;
        in_if.data      = '0;
        in_if.bank_7ffd = '0;
        in_if.bank_1ffd = '0;
        out_if.ready    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_HW_ID;
        cfg_if.wdata    = '0;

        // id reads: reset id, then a new firmware version, then saturation
        rows.push_back(checked(access_row(KIND_READ, PORT_ID, 8'h00, 8'h00, 8'h00),
            mk_result(HW_ID_RESET, 32, 21, 18, 23, 0, 0, 0, 0, 0, 0)));
        rows.push_back(reg_row(CFG_FW_VER, 8'hFF));
        rows.push_back(checked(access_row(KIND_READ, PORT_ID, 8'hFF, 8'hFF, 8'hFF),
            mk_result(8'hFF, 32, 21, 18, 23, 0, 0, 0, 0, 0, 0)));
        rows.push_back(reg_row(CFG_HW_ID, 8'hFF));
        rows.push_back(checked(access_row(KIND_READ, PORT_ID, 8'h00, 8'h00, 8'h00),
            mk_result(READ_IDLE, 32, 21, 18, 23, 0, 0, 0, 0, 0, 0)));
        rows.push_back(access_row(KIND_READ, 16'hFFFF, 8'hAA, 8'h00, 8'h00));
        rows.push_back(checked(access_row(KIND_WRITE, PORT_OPTION, 8'hFF, 8'h00, 8'h00),
            mk_result(READ_IDLE, 32, 21, 18, 23, 0, 0, 1, 1, 0, 0)));
        rows.push_back(checked(access_row(KIND_WRITE, PORT_TURBO, 8'hFF, 8'h00, 8'h00),
            mk_result(READ_IDLE, 32, 21, 18, 23, 0, 0, 1, 1, 1, 0)));
        rows.push_back(checked(access_row(KIND_WRITE, PORT_MODE, 8'h1F, 8'h00, 8'h00),
            mk_result(READ_IDLE, 31, 21, 18, 23, 1, 0, 1, 1, 1, 0)));
        rows.push_back(checked(access_row(KIND_WRITE, PORT_MODE, 8'h40, 8'hFF, 8'hFF),
            mk_result(READ_IDLE, 28, 21, 18, 16, 0, 0, 1, 1, 1, 0)));
        rows.push_back(access_row(KIND_WRITE, PORT_MODE, 8'h80, 8'h17, 8'h00));
        rows.push_back(access_row(KIND_WRITE, PORT_MODE, 8'hC0, 8'h10, 8'h04));
        rows.push_back(access_row(KIND_WRITE, 16'h0000, 8'hFF, 8'h00, 8'h01));
        rows.push_back(access_row(KIND_READ, PORT_MODE, 8'h00, 8'h00, 8'h03));
        rows.push_back(access_row(KIND_WRITE, 16'h24DA, 8'hFF, 8'h00, 8'h05));
        rows.push_back(access_row(KIND_WRITE, 16'h24DC, 8'h00, 8'hFF, 8'hFF));
        rows.push_back(checked(access_row(KIND_WRITE, PORT_RESET, 8'h01, 8'h07, 8'h00),
            mk_result(READ_IDLE, 28, 21, 18, 23, 0, 1, 1, 1, 1, 1)));
        rows.push_back(checked(access_row(KIND_WRITE, PORT_RESET, 8'h02, 8'h00, 8'h00),
            mk_result(READ_IDLE, 32, 21, 18, 23, 0, 1, 1, 1, 1, 0)));
        rows.push_back(access_row(KIND_WRITE, PORT_MODE, 8'h00, 8'h00, 8'h00));
        rows.push_back(checked(access_row(KIND_WRITE, PORT_RESET, 8'h03, 8'h00, 8'h00),
            mk_result(READ_IDLE, 32, 21, 18, 23, 0, 1, 1, 1, 1, 0)));
        rows.push_back(access_row(KIND_WRITE, PORT_RESET, 8'hFC, 8'h00, 8'h00));
        rows.push_back(access_row(KIND_WRITE, PORT_OPTION, 8'h00, 8'h00, 8'h00));
        rows.push_back(access_row(KIND_WRITE, PORT_TURBO, 8'h00, 8'h00, 8'h00));
        rows.push_back(access_row(KIND_WRITE, PORT_MODE, 8'hFF, 8'h00, 8'hFF));
        rows.push_back(access_row(KIND_READ, PORT_ID, 8'h5A, 8'h00, 8'h00));
        rows.push_back(reg_row(CFG_HW_ID, 8'h00));
        rows.push_back(reg_row(CFG_FW_VER, 8'h00));

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].what == ROW_REG) begin
                write_register(rows[i].idx, rows[i].value);
            end else begin
                send_access(rows[i].acc, rows[i].typed, rows[i].want);
                pace();
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            hw_val = (ph == 0) ? 8'hFF : (ph == 1) ? 8'h00 : 8'($urandom_range(0, 255));
            fw_val = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            write_register(CFG_HW_ID, hw_val);
            write_register(CFG_FW_VER, fw_val);
            repeat (RANDOM_ITEMS / PHASES) begin
                send_access(rand_access(), 1'b0, '0);
                pace();
            end
        end

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
